// File: rtl/bvie_pkg.sv
// Shared types and constants for the bounded vector with insert and erase.
package bvie_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = 9;
  localparam int unsigned OP_W   = 4;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 4'd0,
    OP_WRITE  = 4'd1,
    OP_APPEND = 4'd2,
    OP_REMOVE = 4'd3,
    OP_INSERT = 4'd4,
    OP_ERASE  = 4'd5,
    OP_CLEAR  = 4'd6,
    OP_RESIZE = 4'd7,
    OP_ASSIGN = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } st_e;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic [CNT_W-1:0]         count;
    logic [1:0]               status;
  } rsp_t;

endpackage

// File: rtl/bounded_vector_insert_erase.sv
// Bounded vector of signed words: single-port-per-direction store under a small sequencer.
// Write, append, remove, clear, refusals and unused codes go straight to the result state; read
// passes through S_READ; insert and erase shift each entry that moves one place, and insert then
// writes the new word into the gap; resize and assign write their fill word into entries in S_FILL.
// One item at a time: the next item is taken the cycle after its result is registered, and a
// stalled result holds off completion. Reset clears the count and the control state; the
// element store is not cleared, so it needs no sweep after reset.
module bounded_vector_insert_erase
  import bvie_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_INS,
    S_ERA,
    S_FILL,
    S_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         cur_q, cur_d;
  logic [CNT_W-1:0]         left_q, left_d;
  logic [CNT_W-1:0]         end_q, end_d;
  logic [ADDR_W-1:0]        wa_q, wa_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic                     pend_q, pend_d;
  logic [WORD_W-1:0]        fill_q, fill_d;
  logic [WORD_W-1:0]        word_q, word_d;
  st_e                      st_q, st_d;
  logic                     out_valid_q, out_valid_d;
  rsp_t                     out_q, out_d;

  logic                     accept;
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        mem_wa, mem_ra;
  logic [WORD_W-1:0]        mem_wd;
  logic [WORD_W-1:0]        rdata_q;
  logic [WORD_W-1:0]        mem [DEPTH];

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Element store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    left_d      = left_q;
    end_d       = end_q;
    wa_d        = wa_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    fill_d      = fill_q;
    word_d      = word_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wa      = wa_q;
    mem_wd      = rdata_q;
    mem_re      = 1'b0;
    mem_ra      = cur_q[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          word_d  = '0;
          st_d    = ST_OK;
          state_d = S_DONE;
          unique case (in_i.opcode)
            OP_READ: begin
              if (in_i.position < cnt_q) begin
                mem_re  = 1'b1;
                mem_ra  = in_i.position[ADDR_W-1:0];
                state_d = S_READ;
              end else begin
                st_d = ST_RANGE;
              end
            end
            OP_WRITE: begin
              if (in_i.position < cnt_q) begin
                mem_we = 1'b1;
                mem_wa = in_i.position[ADDR_W-1:0];
                mem_wd = in_i.word_in;
              end else begin
                st_d = ST_RANGE;
              end
            end
            OP_APPEND: begin
              if (cnt_q == CNT_W'(DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = cnt_q[ADDR_W-1:0];
                mem_wd = in_i.word_in;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (in_i.position > cnt_q) begin
                st_d = ST_RANGE;
              end else if (cnt_q == CNT_W'(DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                // Move entries up from the top, then drop the new word into the gap.
                left_d  = cnt_q - in_i.position;
                cur_d   = cnt_q - CNT_W'(1);
                pos_d   = in_i.position[ADDR_W-1:0];
                fill_d  = in_i.word_in;
                pend_d  = 1'b0;
                cnt_d   = cnt_q + CNT_W'(1);
                state_d = S_INS;
              end
            end
            OP_ERASE: begin
              if (in_i.position >= cnt_q) begin
                st_d = ST_RANGE;
              end else begin
                left_d  = cnt_q - in_i.position - CNT_W'(1);
                cur_d   = in_i.position + CNT_W'(1);
                pend_d  = 1'b0;
                cnt_d   = cnt_q - CNT_W'(1);
                state_d = S_ERA;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            OP_RESIZE, OP_ASSIGN: begin
              if (in_i.position > POS_W'(DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                // Resize zero-fills only new entries; assign overwrites every live entry.
                if (in_i.opcode == OP_ASSIGN) begin
                  cur_d  = '0;
                  fill_d = in_i.word_in;
                end else begin
                  cur_d  = cnt_q;
                  fill_d = '0;
                end
                end_d   = in_i.position;
                cnt_d   = in_i.position;
                state_d = S_FILL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        word_d  = rdata_q;
        state_d = S_DONE;
      end

      S_INS, S_ERA: begin
        // A word read last cycle is written back one place along this cycle.
        mem_we = pend_q;
        if (left_q != '0) begin
          mem_re = 1'b1;
          if (state_q == S_INS) begin
            wa_d  = cur_q[ADDR_W-1:0] + ADDR_W'(1);
            cur_d = cur_q - CNT_W'(1);
          end else begin
            wa_d  = cur_q[ADDR_W-1:0] - ADDR_W'(1);
            cur_d = cur_q + CNT_W'(1);
          end
          left_d = left_q - CNT_W'(1);
          pend_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          if (state_q == S_INS) begin
            mem_we = 1'b1;
            mem_wa = pos_q;
            mem_wd = fill_q;
          end
          state_d = S_DONE;
        end
      end

      S_FILL: begin
        if (cur_q < end_q) begin
          mem_we = 1'b1;
          mem_wa = cur_q[ADDR_W-1:0];
          mem_wd = fill_q;
          cur_d  = cur_q + CNT_W'(1);
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.word_out = word_q;
          out_d.count    = cnt_q;
          out_d.status   = st_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      left_q      <= '0;
      end_q       <= '0;
      wa_q        <= '0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      fill_q      <= '0;
      word_q      <= '0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      left_q      <= left_d;
      end_q       <= end_d;
      wa_q        <= wa_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      fill_q      <= fill_d;
      word_q      <= word_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("live count exceeds capacity");

  a_pend_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_INS || state_q == S_ERA))
    else $error("pending shift write outside a shift");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without finishing an item");

endmodule
